// File: sv/cme_pkg.sv
// Shared types, constants and arithmetic helpers for the cube-face to
// equirectangular address generator. No dependencies.
package cme_pkg;

  localparam int DIR_W      = 19;
  localparam int SQ_W       = 38;
  localparam int SQRT_STEPS = 19;
  localparam int TAB_LEN    = 28;

  typedef logic signed [DIR_W-1:0] dir_t;
  typedef logic [SQ_W-1:0]         sq_t;
  typedef logic [SQRT_STEPS-1:0]   root_t;
  typedef logic signed [31:0]      cval_t;
  typedef logic [23:0]             turn_t;
  typedef logic [22:0]             ufrac_t;
  typedef logic signed [2:0]       bcoef_t;
  typedef logic [1:0]              cfg_idx_t;
  typedef logic [9:0]              cfg_data_t;

  localparam turn_t HALF_TURN = 24'h800000;

  localparam cfg_idx_t REG_FACE = 2'd0;
  localparam cfg_idx_t REG_LON  = 2'd1;
  localparam cfg_idx_t REG_CHAN = 2'd2;

  typedef struct packed {
    dir_t d0;
    dir_t d1;
    dir_t d2;
  } dir_vec_t;

  typedef struct packed {
    cval_t       x;
    cval_t       y;
    logic [31:0] acc;
    logic        zero;
    turn_t       zval;
  } lane_t;

  // per face: corner, down, right
  localparam bcoef_t FACE_BASIS [6][3][3] = '{
    '{'{ 3'sd1,  3'sd1,  3'sd1}, '{ 3'sd0, -3'sd2,  3'sd0}, '{-3'sd2,  3'sd0,  3'sd0}},
    '{'{-3'sd1,  3'sd1, -3'sd1}, '{ 3'sd2,  3'sd0,  3'sd0}, '{ 3'sd0,  3'sd0,  3'sd2}},
    '{'{ 3'sd1,  3'sd1, -3'sd1}, '{ 3'sd0, -3'sd2,  3'sd0}, '{ 3'sd0,  3'sd0,  3'sd2}},
    '{'{-3'sd1,  3'sd1, -3'sd1}, '{ 3'sd0, -3'sd2,  3'sd0}, '{ 3'sd2,  3'sd0,  3'sd0}},
    '{'{ 3'sd1, -3'sd1, -3'sd1}, '{-3'sd2,  3'sd0,  3'sd0}, '{ 3'sd0,  3'sd0,  3'sd2}},
    '{'{-3'sd1,  3'sd1,  3'sd1}, '{ 3'sd0, -3'sd2,  3'sd0}, '{ 3'sd0,  3'sd0, -3'sd2}}
  };

  // atan(2^-i) in turns, 2^32 per turn
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  // divide by 45 through a reciprocal, exact for dividends below 2^30
  localparam int          ROT_S = 36;
  localparam longint      ROT_ML = ((64'd1 << ROT_S) + 64'd44) / 64'd45;
  localparam logic [30:0] ROT_M = 31'(ROT_ML);

  // rotation in turns: round(|deg rem 360| * 2^24 / 360), negated for negative
  function automatic turn_t rot_turns(logic signed [9:0] deg);
    logic [9:0]  mag;
    logic [32:0] num;
    logic [29:0] num8;
    logic [60:0] prod;
    turn_t       q;
    mag = deg[9] ? 10'(-deg) : 10'(deg);
    if (mag >= 10'd360) begin
      mag = mag - 10'd360;
    end
    num  = {mag[8:0], 24'b0} + 33'd180;
    num8 = num[32:3];
    prod = 61'(num8) * 61'(ROT_M);
    q    = 24'(prod >> ROT_S);
    return deg[9] ? 24'(-q) : q;
  endfunction

  function automatic dir_t dir_comp(bcoef_t tl, bcoef_t rt, bcoef_t dn, ufrac_t u,
                                    ufrac_t v);
    logic signed [27:0] c;
    logic signed [27:0] us;
    logic signed [27:0] vs;
    us = 28'(signed'({1'b0, u}));
    vs = 28'(signed'({1'b0, v}));
    c  = (28'(tl) <<< 16) + 28'(rt) * us + 28'(dn) * vs;
    if (c > 28'sd262143) begin
      return 19'sd262143;
    end else if (c < -28'sd262144) begin
      return -19'sd262144;
    end
    return 19'(c);
  endfunction

  function automatic lane_t cordic_init(logic signed [19:0] num, logic signed [19:0] den);
    lane_t l;
    l.zero = (num == 20'sd0);
    l.zval = den[19] ? HALF_TURN : '0;
    if (den[19]) begin
      l.x   = -32'(den);
      l.y   = -32'(num);
      l.acc = 32'h80000000;
    end else begin
      l.x   = 32'(den);
      l.y   = 32'(num);
      l.acc = '0;
    end
    l.x = l.x <<< 10;
    l.y = l.y <<< 10;
    return l;
  endfunction

  function automatic lane_t cordic_step(lane_t l, int i);
    lane_t o;
    cval_t dx;
    cval_t dy;
    o  = l;
    dx = l.y >>> i;
    dy = l.x >>> i;
    if (!l.y[31]) begin
      o.x   = l.x + dx;
      o.y   = l.y - dy;
      o.acc = l.acc + ATAN_TAB[i];
    end else begin
      o.x   = l.x - dx;
      o.y   = l.y + dy;
      o.acc = l.acc - ATAN_TAB[i];
    end
    return o;
  endfunction

  function automatic turn_t cordic_result(lane_t l);
    logic [31:0] r;
    r = l.acc + 32'd128;
    return l.zero ? l.zval : r[31:8];
  endfunction

endpackage

// File: sv/cme_ifs.sv
// Channel interfaces: face pixel input, source address output, register writes.
// Depends on cme_pkg.
interface cme_in_if;
  logic       valid;
  logic       ready;
  logic [8:0] face_col;
  logic [8:0] face_row;
  modport source(output valid, face_col, face_row, input ready);
  modport sink(input valid, face_col, face_row, output ready);
endinterface

interface cme_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] source_col;
  logic [9:0]  source_row;
  logic [22:0] source_offset;
  modport source(output valid, source_col, source_row, source_offset, input ready);
  modport sink(input valid, source_col, source_row, source_offset, output ready);
endinterface

interface cme_cfg_if;
  logic                valid;
  logic                ready;
  cme_pkg::cfg_idx_t   index;
  cme_pkg::cfg_data_t  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: sv/cubemap_to_equirect_address.sv
// Cube-face pixel to equirectangular source address generator, top level.
// Depends on cme_pkg, cme_ifs, cme_sqrt_cell, cme_cordic_cell.
//
// Usage:
//   in_if  : one cube-face pixel (face_col, face_row) per transfer.
//   out_if : source column, row and element offset, one per input transfer,
//            in input order.
//   cfg_if : register writes (0 face select, 1 longitude offset in degrees,
//            2 channel count); always ready, write only while idle.
// Throughput: one pixel per cycle while the output is not stalled. Every
// stage is a register, so any input pattern streams without bubbles.
// Pipeline: the face coordinates and direction stages (A, B), the squared
// radius stages (C, D), 19 square root digit cells, one CORDIC setup stage,
// CORDIC_STEPS iteration cells and three stages for scaling and the offset
// product.
// Reset: all pipeline valid bits clear, registers return to face 0,
// no rotation and three channels.
// Stall: while the output register holds a transfer that is not taken,
// the whole pipeline holds and in_if.ready is low; nothing is dropped.
module cubemap_to_equirect_address #(
  parameter int FACE_SIZE    = 512,
  parameter int CORDIC_STEPS = 20
) (
  input  logic     clk,
  input  logic     rst_n,
  cme_in_if.sink   in_if,
  cme_out_if.source out_if,
  cme_cfg_if.sink  cfg_if
);
  localparam int     DEN    = 2 * FACE_SIZE;
  localparam int     US     = 27 + $clog2(DEN);
  localparam longint UML    = ((64'd1 << US) + 64'(DEN) - 64'd1) / 64'(DEN);
  localparam int     W      = 4 * FACE_SIZE;
  localparam int     H      = 2 * FACE_SIZE;
  localparam int     CW     = $clog2(W);
  localparam int     RW     = $clog2(H);
  localparam int     PW     = CW + RW;
  localparam logic [28:0] UM = 29'(UML);

  logic en;

  // configuration registers
  logic [2:0]        face_sel_r;
  logic signed [9:0] lon_off_r;
  logic [2:0]        ch_cnt_r;
  cme_pkg::turn_t    rot_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_sel_r <= '0;
      lon_off_r  <= '0;
      ch_cnt_r   <= 3'd3;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        cme_pkg::REG_FACE: face_sel_r <= cfg_if.data[2:0];
        cme_pkg::REG_LON:  lon_off_r  <= signed'(cfg_if.data);
        cme_pkg::REG_CHAN: ch_cnt_r   <= cfg_if.data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= cme_pkg::rot_turns(lon_off_r);
  end

  // stage A: u, v through reciprocal multiply
  logic              vld_a_r;
  cme_pkg::ufrac_t   u_r, v_r;
  logic [26:0]       nu, nv;
  logic [55:0]       pu, pv;

  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  always_comb begin
    nu = {1'b0, in_if.face_col, 1'b1, 16'b0} + 27'(FACE_SIZE);
    nv = {1'b0, in_if.face_row, 1'b1, 16'b0} + 27'(FACE_SIZE);
    pu = 56'(nu) * 56'(UM);
    pv = 56'(nv) * 56'(UM);
  end

  // stage B: direction
  logic              vld_b_r;
  cme_pkg::dir_vec_t dir_b_r, dir_b_nxt;
  logic [2:0]        fsel;

  always_comb begin
    fsel = (face_sel_r < 3'd6) ? face_sel_r : 3'd0;
    dir_b_nxt.d0 = cme_pkg::dir_comp(cme_pkg::FACE_BASIS[fsel][0][0],
      cme_pkg::FACE_BASIS[fsel][2][0], cme_pkg::FACE_BASIS[fsel][1][0], u_r, v_r);
    dir_b_nxt.d1 = cme_pkg::dir_comp(cme_pkg::FACE_BASIS[fsel][0][1],
      cme_pkg::FACE_BASIS[fsel][2][1], cme_pkg::FACE_BASIS[fsel][1][1], u_r, v_r);
    dir_b_nxt.d2 = cme_pkg::dir_comp(cme_pkg::FACE_BASIS[fsel][0][2],
      cme_pkg::FACE_BASIS[fsel][2][2], cme_pkg::FACE_BASIS[fsel][1][2], u_r, v_r);
  end

  // stage C: squares, stage D: sum
  logic              vld_c_r, vld_d_r;
  cme_pkg::dir_vec_t dir_c_r, dir_d_r;
  logic [36:0]       sq0_r, sq2_r;
  logic signed [37:0] p0, p2;
  cme_pkg::sq_t      sum_r;

  always_comb begin
    p0 = 38'(dir_b_r.d0) * 38'(dir_b_r.d0);
    p2 = 38'(dir_b_r.d2) * 38'(dir_b_r.d2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_if.valid;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
      vld_d_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r     <= 23'(pu >> US);
      v_r     <= 23'(pv >> US);
      dir_b_r <= dir_b_nxt;
      sq0_r   <= p0[36:0];
      sq2_r   <= p2[36:0];
      dir_c_r <= dir_b_r;
      sum_r   <= 38'(sq0_r) + 38'(sq2_r);
      dir_d_r <= dir_c_r;
    end
  end

  // square root chain
  logic              sv [cme_pkg::SQRT_STEPS+1];
  cme_pkg::sq_t      sn [cme_pkg::SQRT_STEPS+1];
  cme_pkg::sq_t      sres [cme_pkg::SQRT_STEPS+1];
  cme_pkg::dir_vec_t sp [cme_pkg::SQRT_STEPS+1];

  assign sv[0]   = vld_d_r;
  assign sn[0]   = sum_r;
  assign sres[0] = '0;
  assign sp[0]   = dir_d_r;

  for (genvar k = 0; k < cme_pkg::SQRT_STEPS; k++) begin : g_sqrt
    cme_sqrt_cell #(.K(k)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_vld(sv[k]), .in_n(sn[k]), .in_res(sres[k]), .in_pass(sp[k]),
      .out_vld(sv[k+1]), .out_n(sn[k+1]), .out_res(sres[k+1]), .out_pass(sp[k+1])
    );
  end

  // CORDIC setup
  logic           vld_p_r;
  cme_pkg::lane_t cl_lon [CORDIC_STEPS+1];
  cme_pkg::lane_t cl_lat [CORDIC_STEPS+1];
  logic           cv [CORDIC_STEPS+1];
  cme_pkg::lane_t lon_p_r, lat_p_r;
  cme_pkg::root_t root;

  assign root = sres[cme_pkg::SQRT_STEPS][cme_pkg::SQRT_STEPS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p_r <= 1'b0;
    end else if (en) begin
      vld_p_r <= sv[cme_pkg::SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lon_p_r <= cme_pkg::cordic_init(20'(sp[cme_pkg::SQRT_STEPS].d2),
                                      20'(sp[cme_pkg::SQRT_STEPS].d0));
      lat_p_r <= cme_pkg::cordic_init(signed'({1'b0, root}),
                                      20'(sp[cme_pkg::SQRT_STEPS].d1));
    end
  end

  assign cv[0]     = vld_p_r;
  assign cl_lon[0] = lon_p_r;
  assign cl_lat[0] = lat_p_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    cme_cordic_cell #(.I(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_vld(cv[i]), .in_lon(cl_lon[i]), .in_lat(cl_lat[i]),
      .out_vld(cv[i+1]), .out_lon(cl_lon[i+1]), .out_lat(cl_lat[i+1])
    );
  end

  // F1: angles to column and row
  cme_pkg::turn_t lon, lat;
  logic [39:0]    pc, pr;
  logic [CW-1:0]  raw_row;
  logic           vld_f1_r, vld_f2_r;
  logic [CW-1:0]  scol_f1_r, scol_f2_r;
  logic [RW-1:0]  srow_f1_r, srow_f1_nxt, srow_f2_r;
  logic [PW-1:0]  pix_r;

  always_comb begin
    lon     = cme_pkg::cordic_result(cl_lon[CORDIC_STEPS]) + cme_pkg::HALF_TURN - rot_r;
    lat     = cme_pkg::cordic_result(cl_lat[CORDIC_STEPS]);
    pc      = 40'(lon) * 40'(W);
    pr      = 40'(lat) * 40'(W);
    raw_row = CW'(pr >> 24);
    // row product is below twice the height: one conditional subtract wraps it
    srow_f1_nxt = (raw_row >= CW'(H)) ? RW'(raw_row - CW'(H)) : RW'(raw_row);
  end

  // output register
  logic          out_vld_r;
  logic [10:0]   out_col_r;
  logic [9:0]    out_row_r;
  logic [22:0]   out_off_r;
  logic [PW+2:0] offw;

  assign offw = (PW+3)'(pix_r) * (PW+3)'(ch_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_f1_r  <= 1'b0;
      vld_f2_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_f1_r  <= cv[CORDIC_STEPS];
      vld_f2_r  <= vld_f1_r;
      out_vld_r <= vld_f2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scol_f1_r <= CW'(pc >> 24);
      srow_f1_r <= srow_f1_nxt;
      pix_r     <= PW'(srow_f1_r) * PW'(W) + PW'(scol_f1_r);
      scol_f2_r <= scol_f1_r;
      srow_f2_r <= srow_f1_r;
      out_col_r <= 11'(scol_f2_r);
      out_row_r <= 10'(srow_f2_r);
      out_off_r <= 23'(offw);
    end
  end

  assign out_if.valid         = out_vld_r;
  assign out_if.source_col    = out_col_r;
  assign out_if.source_row    = out_row_r;
  assign out_if.source_offset = out_off_r;
endmodule

// File: sv/cme_sqrt_cell.sv
// One digit of the integer square root chain; carries the direction along.
// Depends on cme_pkg.
module cme_sqrt_cell #(
  parameter int K = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  cme_pkg::sq_t      in_n,
  input  cme_pkg::sq_t      in_res,
  input  cme_pkg::dir_vec_t in_pass,
  output logic              out_vld,
  output cme_pkg::sq_t      out_n,
  output cme_pkg::sq_t      out_res,
  output cme_pkg::dir_vec_t out_pass
);
  localparam cme_pkg::sq_t BIT = cme_pkg::sq_t'(1) << (cme_pkg::SQ_W - 2 - 2 * K);

  logic              vld_r;
  cme_pkg::sq_t      n_r, n_nxt;
  cme_pkg::sq_t      res_r, res_nxt;
  cme_pkg::dir_vec_t pass_r;
  cme_pkg::sq_t      trial;

  always_comb begin
    trial = in_res + BIT;
    if (in_n >= trial) begin
      n_nxt   = in_n - trial;
      res_nxt = (in_res >> 1) + BIT;
    end else begin
      n_nxt   = in_n;
      res_nxt = in_res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      res_r  <= res_nxt;
      pass_r <= in_pass;
    end
  end

  assign out_vld  = vld_r;
  assign out_n    = n_r;
  assign out_res  = res_r;
  assign out_pass = pass_r;
endmodule

// File: sv/cme_cordic_cell.sv
// One CORDIC vectoring iteration for both angle lanes (longitude, latitude).
// Depends on cme_pkg.
module cme_cordic_cell #(
  parameter int I = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  cme_pkg::lane_t in_lon,
  input  cme_pkg::lane_t in_lat,
  output logic           out_vld,
  output cme_pkg::lane_t out_lon,
  output cme_pkg::lane_t out_lat
);
  logic           vld_r;
  cme_pkg::lane_t lon_r, lon_nxt;
  cme_pkg::lane_t lat_r, lat_nxt;

  always_comb begin
    lon_nxt = cme_pkg::cordic_step(in_lon, I);
    lat_nxt = cme_pkg::cordic_step(in_lat, I);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lon_r <= lon_nxt;
      lat_r <= lat_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_lon = lon_r;
  assign out_lat = lat_r;
endmodule

// File: sv/cme_checker.sv
// Port-level checks for the address generator, bound to the top level.
// Depends on cubemap_to_equirect_address.
module cme_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] out_source_col,
  input logic [9:0]  out_source_row,
  input logic [22:0] out_source_offset
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_source_col) && $stable(out_source_row)
      && $stable(out_source_offset))
    else $error("result changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output register");

  // input only waits behind a stalled result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");
endmodule

bind cubemap_to_equirect_address cme_checker u_cme_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_if.valid),
  .in_ready(in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_source_col(out_if.source_col),
  .out_source_row(out_if.source_row),
  .out_source_offset(out_if.source_offset)
);
